FILE: design/bsfc_pkg.sv
package bsfc_pkg;

    // field and datapath widths
    localparam int DUTY_W    = 17;
    localparam int DIV_NUM_W = 31;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_REM_W = DIV_DEN_W + 1;
    localparam int DIV_CNT_W = 5;
    localparam int SUM_W     = 32;

    // last step index of the restoring divider (one quotient bit per step)
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    // full duty in q16 and the lowest plausible temperature reading
    localparam logic [DUTY_W-1:0] FULL_DUTY      = 17'd65536;
    localparam logic signed [15:0] MIN_TEMP_DECIC = -16'sd500;

    // configuration register indexes
    localparam logic [2:0] CFG_UV_TRIP    = 3'd0;
    localparam logic [2:0] CFG_UV_RESTART = 3'd1;
    localparam logic [2:0] CFG_OC_TRIP    = 3'd2;
    localparam logic [2:0] CFG_OT_TRIP    = 3'd3;
    localparam logic [2:0] CFG_SOFT_START = 3'd4;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_ARMING = 3'd1,
        MODE_SOFT   = 3'd2,
        MODE_RUN    = 3'd3,
        MODE_FAULT  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CAUSE_NONE  = 3'd0,
        CAUSE_UV    = 3'd1,
        CAUSE_OC    = 3'd2,
        CAUSE_OT    = 3'd3,
        CAUSE_INPUT = 3'd4
    } t_cause;

    typedef struct packed {
        logic               trigger;
        logic               readings_invalid;
        logic               time_invalid;
        logic signed [15:0] voltage_mv;
        logic signed [15:0] current_ma;
        logic signed [15:0] temp_decic;
        logic signed [15:0] dt_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        mode;
        logic [2:0]        fault_cause;
        logic [DUTY_W-1:0] duty_q16;
    } t_out_item;

    typedef struct packed {
        logic [15:0]          uv_trip_mv;
        logic [15:0]          uv_restart_mv;
        logic [15:0]          oc_trip_ma;
        logic signed [11:0]   ot_trip_decic;
        logic [DIV_DEN_W-1:0] soft_start_us;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_step;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_status;

endpackage

FILE: design/blower_soft_start_fault_controller.sv
// one beat in flight; the result is registered after the eval state, or for a
// soft-start tick with a nonzero ramp time after the 31-step restoring divider
// next beat accepted once the result is registered, which is held off only while
// the result register waits on the consumer
// synchronous active-low reset: thresholds to defaults, mode off, no fault,
// zero duty, no result pending
module blower_soft_start_fault_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bsfc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bsfc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    bsfc_pkg::t_cfg    r_cfg;
    bsfc_pkg::t_cmd    cmd;
    bsfc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_trip_mv    <= 16'd16000;
            r_cfg.uv_restart_mv <= 16'd17000;
            r_cfg.oc_trip_ma    <= 16'd30000;
            r_cfg.ot_trip_decic <= 12'sd800;
            r_cfg.soft_start_us <= 24'd1000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bsfc_pkg::CFG_UV_TRIP:    r_cfg.uv_trip_mv    <= i_cfg_data[15:0];
                bsfc_pkg::CFG_UV_RESTART: r_cfg.uv_restart_mv <= i_cfg_data[15:0];
                bsfc_pkg::CFG_OC_TRIP:    r_cfg.oc_trip_ma    <= i_cfg_data[15:0];
                bsfc_pkg::CFG_OT_TRIP:    r_cfg.ot_trip_decic <= $signed(i_cfg_data[11:0]);
                bsfc_pkg::CFG_SOFT_START: r_cfg.soft_start_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // controller
    bsfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    bsfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // duty only while ramping or running
    a_duty_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duty_q16 == '0) ||
                        (o_out_data.mode == bsfc_pkg::MODE_SOFT) ||
                        (o_out_data.mode == bsfc_pkg::MODE_RUN))
        else $error("duty driven outside soft start or run");

    // a cause is reported exactly when latched
    a_cause_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.mode == bsfc_pkg::MODE_FAULT) ==
                         (o_out_data.fault_cause != bsfc_pkg::CAUSE_NONE)))
        else $error("fault cause and mode disagree");

    // duty never beyond full scale
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duty_q16 <= bsfc_pkg::FULL_DUTY))
        else $error("duty above full scale");

    // one beat at a time
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while busy");
`endif

endmodule

FILE: design/bsfc_ctrl.sv
module bsfc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bsfc_pkg::t_status i_status,
    output bsfc_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT
    } t_state;

    t_state                            r_state;
    logic [bsfc_pkg::DIV_CNT_W-1:0]    r_cnt;

    // commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_item = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == ST_EVAL) && i_status.need_div;
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.commit    = (r_state == ST_COMMIT) && !i_status.out_busy;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // sequencer: take beat, decide, optional ramp divide, commit result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_cnt <= '0;
                    if (i_status.need_div) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == bsfc_pkg::DIV_LAST) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_COMMIT: begin
                    if (!i_status.out_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/bsfc_dp.sv
module bsfc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsfc_pkg::t_cmd      i_cmd,
    output bsfc_pkg::t_status   o_status,
    input  bsfc_pkg::t_cfg      i_cfg,
    input  bsfc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bsfc_pkg::t_out_item o_out_data
);

    // captured beat and controller state
    bsfc_pkg::t_in_item                r_item;
    bsfc_pkg::t_mode                   r_mode;
    bsfc_pkg::t_cause                  r_cause;
    logic [bsfc_pkg::DUTY_W-1:0]       r_duty;

    // restoring divider
    logic [bsfc_pkg::DIV_REM_W-1:0]    r_rem;
    logic [bsfc_pkg::DIV_NUM_W-1:0]    r_num;
    logic [bsfc_pkg::DIV_NUM_W-1:0]    r_quo;

    // output register
    logic                              r_out_valid;
    bsfc_pkg::t_out_item               r_out;

    logic signed [15:0]                v;
    logic signed [15:0]                i;
    logic signed [15:0]                t;
    logic signed [15:0]                ot_ext;
    logic                              in_fault;
    logic                              ot_hit;
    logic                              oc_hit;
    logic                              uv_hit;
    logic                              clear_base;
    logic                              may_clear;
    logic                              need_div;
    logic [bsfc_pkg::SUM_W-1:0]        ramp_sum;
    logic [bsfc_pkg::DIV_REM_W-1:0]    rem_shift;
    logic [bsfc_pkg::DIV_REM_W-1:0]    den_ext;
    bsfc_pkg::t_mode                   n_mode;
    bsfc_pkg::t_cause                  n_cause;
    logic [bsfc_pkg::DUTY_W-1:0]       n_duty;

    assign v      = r_item.voltage_mv;
    assign i      = r_item.current_ma;
    assign t      = r_item.temp_decic;
    assign ot_ext = {{4{i_cfg.ot_trip_decic[11]}}, i_cfg.ot_trip_decic};

    // trip checks; current and voltage compared on 17 bits against the unsigned thresholds
    assign in_fault = r_item.readings_invalid || r_item.time_invalid ||
                      r_item.dt_us[15] || v[15] || i[15] ||
                      (t < bsfc_pkg::MIN_TEMP_DECIC);
    assign ot_hit   = (t >= ot_ext);
    assign oc_hit   = ($signed({i[15], i}) >= $signed({1'b0, i_cfg.oc_trip_ma}));
    assign uv_hit   = ($signed({v[15], v}) < $signed({1'b0, i_cfg.uv_trip_mv}));

    // latch release conditions
    assign clear_base = !r_item.readings_invalid && !i[15] &&
                        (t >= bsfc_pkg::MIN_TEMP_DECIC);
    always_comb begin
        case (r_cause)
            bsfc_pkg::CAUSE_UV, bsfc_pkg::CAUSE_INPUT: begin
                may_clear = clear_base &&
                    ($signed({v[15], v}) >= $signed({1'b0, i_cfg.uv_restart_mv}));
            end
            bsfc_pkg::CAUSE_OC: begin
                may_clear = clear_base &&
                    ($signed({i[15], i}) < $signed({1'b0, i_cfg.oc_trip_ma}));
            end
            bsfc_pkg::CAUSE_OT: begin
                may_clear = clear_base && (t < ot_ext);
            end
            default: begin
                may_clear = 1'b0;
            end
        endcase
    end

    // ramp sum from the finished quotient
    assign ramp_sum = {{(bsfc_pkg::SUM_W - bsfc_pkg::DUTY_W){1'b0}}, r_duty} +
                      {{(bsfc_pkg::SUM_W - bsfc_pkg::DIV_NUM_W){1'b0}}, r_quo};

    // next state of the controller registers
    always_comb begin
        n_mode   = r_mode;
        n_cause  = r_cause;
        n_duty   = r_duty;
        need_div = 1'b0;
        if (r_mode == bsfc_pkg::MODE_FAULT) begin
            n_duty = '0;
            if (!r_item.trigger && may_clear) begin
                n_mode  = bsfc_pkg::MODE_OFF;
                n_cause = bsfc_pkg::CAUSE_NONE;
            end
        end else if (!r_item.trigger) begin
            n_mode  = bsfc_pkg::MODE_OFF;
            n_cause = bsfc_pkg::CAUSE_NONE;
            n_duty  = '0;
        end else if (in_fault) begin
            n_mode  = bsfc_pkg::MODE_FAULT;
            n_cause = bsfc_pkg::CAUSE_INPUT;
            n_duty  = '0;
        end else if (ot_hit) begin
            n_mode  = bsfc_pkg::MODE_FAULT;
            n_cause = bsfc_pkg::CAUSE_OT;
            n_duty  = '0;
        end else if (oc_hit) begin
            n_mode  = bsfc_pkg::MODE_FAULT;
            n_cause = bsfc_pkg::CAUSE_OC;
            n_duty  = '0;
        end else if (uv_hit) begin
            n_mode  = bsfc_pkg::MODE_FAULT;
            n_cause = bsfc_pkg::CAUSE_UV;
            n_duty  = '0;
        end else begin
            case (r_mode)
                bsfc_pkg::MODE_OFF: begin
                    n_mode = bsfc_pkg::MODE_ARMING;
                    n_duty = '0;
                end
                bsfc_pkg::MODE_ARMING: begin
                    n_mode = bsfc_pkg::MODE_SOFT;
                    n_duty = '0;
                end
                bsfc_pkg::MODE_SOFT: begin
                    if (i_cfg.soft_start_us == '0) begin
                        n_mode = bsfc_pkg::MODE_RUN;
                        n_duty = bsfc_pkg::FULL_DUTY;
                    end else begin
                        need_div = 1'b1;
                        if (ramp_sum >= bsfc_pkg::SUM_W'(bsfc_pkg::FULL_DUTY)) begin
                            n_mode = bsfc_pkg::MODE_RUN;
                            n_duty = bsfc_pkg::FULL_DUTY;
                        end else begin
                            n_duty = ramp_sum[bsfc_pkg::DUTY_W-1:0];
                        end
                    end
                end
                bsfc_pkg::MODE_RUN: begin
                    n_duty = bsfc_pkg::FULL_DUTY;
                end
                default: begin
                    n_mode  = bsfc_pkg::MODE_FAULT;
                    n_cause = bsfc_pkg::CAUSE_INPUT;
                    n_duty  = '0;
                end
            endcase
        end
    end

    // one quotient bit per step
    assign den_ext   = {1'b0, i_cfg.soft_start_us};
    assign rem_shift = {r_rem[bsfc_pkg::DIV_REM_W-2:0], r_num[bsfc_pkg::DIV_NUM_W-1]};

    assign o_status.need_div = need_div;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // input capture and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.div_start) begin
            r_num <= {r_item.dt_us[14:0], 16'b0};
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[bsfc_pkg::DIV_NUM_W-2:0], 1'b0};
            if (rem_shift >= den_ext) begin
                r_rem <= rem_shift - den_ext;
                r_quo <= {r_quo[bsfc_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift;
                r_quo <= {r_quo[bsfc_pkg::DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    // state registers and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bsfc_pkg::MODE_OFF;
            r_cause     <= bsfc_pkg::CAUSE_NONE;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_mode      <= n_mode;
            r_cause     <= n_cause;
            r_duty      <= n_duty;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.mode        <= n_mode;
            r_out.fault_cause <= n_cause;
            r_out.duty_q16    <= n_duty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
